// File: rtl/ray_march_shade_pixel_unit_assert.svh
// assertion macros for the ray march shading unit
// expects signals named clock and reset in the module that uses them
`ifndef RAY_MARCH_SHADE_PIXEL_UNIT_ASSERT_SVH
`define RAY_MARCH_SHADE_PIXEL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RMSP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define RMSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define RMSP_ASSERT_SAME(lbl, ante, cons)
`define RMSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/rmsp_pkg.sv
// types, fixed point constants and helper functions for the ray march shading unit
// no dependencies
package rmsp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_W       = 32 + FRAC_BITS;
   localparam int CNT_W       = $clog2(DIV_W);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   typedef logic signed [31:0] fx_type;
   typedef fx_type vec_type [0:2];

   localparam longint ONE_L  = longint'(1) << FRAC_BITS;
   localparam longint FAR_L  = longint'(128) << FRAC_BITS;

   localparam fx_type FX_MAX  = 32'sh7fffffff;
   localparam fx_type FX_ONE  = 32'(ONE_L);
   localparam fx_type FX_FIVE = 32'(5 * ONE_L);
   localparam fx_type FX_SIX  = 32'(6 * ONE_L);
   localparam fx_type FX_MSIX = 32'(-6 * ONE_L);
   localparam fx_type FX_SURF = 32'(((longint'(25) << FRAC_BITS) + 500) / 1000);
   localparam fx_type FX_EPS  = 32'((ONE_L + 50) / 100);
   localparam fx_type FX_FAR  = (FAR_L > 64'sd2147483647) ? FX_MAX : 32'(FAR_L);

   // x / 10 as a multiply by ceil(2^35 / 10), exact for any 32 bit x
   localparam logic signed [32:0] RECIP10       = 33'sd3435973837;
   localparam int                 RECIP10_SHIFT = 35;

   localparam logic signed [65:0] RND66 = 66'(ONE_L - 1);
   localparam logic signed [65:0] MAX66 = 66'sd2147483647;
   localparam logic signed [65:0] MIN66 = -66'sd2147483648;
   localparam logic signed [33:0] MAX34 = 34'sd2147483647;
   localparam logic signed [33:0] MIN34 = -34'sd2147483648;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS    = 2'd3;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } rmsp_req_type;

   typedef struct packed {
      logic [7:0] intensity;
      logic       shadowed;
   } rmsp_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LSQ, S_SQRT, S_LEN_DONE, S_DLOAD, S_DIV, S_DEND, S_NORM_DONE,
      S_MCHK, S_MMUL, S_SCENE, S_MUPD, S_DOT, S_SCALE, S_SCALE2, S_OUT
   } rmsp_state_type;

   typedef enum logic [3:0] {
      PH_DIR, PH_MARCH, PH_HIT, PH_LDIR, PH_D0, PH_NX, PH_NY, PH_NZ, PH_NRM,
      PH_DIFF, PH_SHADE
   } rmsp_phase_type;

   function automatic logic signed [33:0] sx34(input fx_type v);
      return $signed({{2{v[31]}}, v});
   endfunction

   function automatic fx_type sat34(input logic signed [33:0] v);
      fx_type r;
      if (v > MAX34) r = FX_MAX;
      else if (v < MIN34) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic fx_type sat66(input logic signed [65:0] v);
      fx_type r;
      if (v > MAX66) r = FX_MAX;
      else if (v < MIN66) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // product back to fixed point, truncated toward zero
   function automatic fx_type fx_scale(input logic signed [65:0] p);
      logic signed [65:0] adj;
      adj = p + (p[65] ? RND66 : 66'sd0);
      return sat66(adj >>> FRAC_BITS);
   endfunction

   function automatic logic [31:0] mag32(input fx_type v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic fx_type pick3(input vec_type v, input logic [1:0] k);
      fx_type r;
      unique case (k)
         2'd0:    r = v[0];
         2'd1:    r = v[1];
         default: r = v[2];
      endcase
      return r;
   endfunction

endpackage

// File: rtl/ray_march_shade_pixel_unit.sv
// sphere traced grey shading of one pixel, top level and whole datapath
// depends on rmsp_pkg and ray_march_shade_pixel_unit_assert.svh
//
// Usage: one pixel coordinate enters on the req_ channel (pixel_x, pixel_y),
// one result leaves on the rsp_ channel (intensity, shadowed). A transaction
// completes when valid is high and stall is low. The csr_ port writes the
// image size, focal length and march step limit; write it only while idle.
// Each march step costs one pass of the bit-serial square root plus the
// shared multiplier; each normalization costs one square root and three
// passes of the restoring divider, and a zero length vector skips the
// divider. One pixel is worked on at a time; req_stall stays high until the
// sequencer is back in idle, which happens once the result is in the output
// register, so a new pixel is taken after that. A finished result waits in
// the output register while rsp_stall is high; the next pixel is accepted
// meanwhile, and its result waits in the sequencer until the register frees
// up.
// Reset (synchronous) returns the sequencer to idle, drops rsp_valid and
// loads the registers with 640, 480, 106417 and 128.
`include "ray_march_shade_pixel_unit_assert.svh"

module ray_march_shade_pixel_unit import rmsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rmsp_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rmsp_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   rmsp_state_type state_ff, state_in;
   rmsp_phase_type phase_ff, phase_in;

   logic [12:0] image_width_ff, image_width_in;
   logic [12:0] image_height_ff, image_height_in;
   logic [19:0] focal_length_ff, focal_length_in;
   logic [7:0]  max_steps_ff, max_steps_in;

   vec_type vin_ff, vin_in, p_ff, p_in, org_ff, org_in, mdir_ff, mdir_in;
   vec_type hit_ff, hit_in, ldir_ff, ldir_in, vout_ff, vout_in;

   fx_type t_ff, t_in, s_ff, s_in, d0_ff, d0_in, ldist_ff, ldist_in, diff_ff, diff_in;
   logic signed [33:0] dot_ff, dot_in;
   logic [7:0]  n_ff, n_in;
   logic        brk_ff, brk_in;
   logic        msel_ff, msel_in;
   logic        smode_ff, smode_in;
   logic        shadow_ff, shadow_in;
   logic [1:0]  k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [63:0] acc_ff, acc_in, res_ff, res_in, one_ff, one_in;
   logic [DIV_W-1:0] div_num_ff, div_num_in;
   logic [31:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic        sgn_ff, sgn_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p_ff;

   logic [7:0]   ires_ff, ires_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rmsp_rsp_type rsp_data_ff, rsp_data_in;

   // shared helper values
   fx_type f_res, len_sat, sd, scene_s, t_next, nrm_new, p_new;
   logic [31:0] len_u;
   logic [1:0]  km1;
   logic        march_done, shadow_now;
   logic [63:0] sq_sum;
   logic        sq_ge;
   logic [32:0] rem_sh, rem_sub;
   logic        div_ge;
   logic [31:0] div_q;
   fx_type      div_val;
   logic [31:0] q10;
   fx_type      div10_val;
   logic signed [14:0] raw_xw, raw_yw;
   logic signed [65:0] out_sh;

   assign f_res      = fx_scale(mul_p_ff);
   assign len_u      = res_ff[31:0];
   assign len_sat    = len_u[31] ? FX_MAX : $signed(len_u);
   assign sd         = sat34(sx34(len_sat) - sx34(FX_ONE));
   assign scene_s    = (sd < p_ff[1]) ? sd : p_ff[1];
   assign t_next     = sat34(sx34(t_ff) + sx34(s_ff));
   assign nrm_new    = sat34(sx34(scene_s) - sx34(d0_ff));
   assign km1        = k_ff - 2'd1;
   assign p_new      = sat34(sx34(pick3(org_ff, km1)) + sx34(f_res));
   assign march_done = (n_ff >= max_steps_ff) || brk_ff;
   assign shadow_now = t_ff < ldist_ff;
   assign sq_sum     = res_ff + one_ff;
   assign sq_ge      = acc_ff >= sq_sum;
   assign rem_sh     = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_ge     = rem_sh >= {1'b0, div_den_ff};
   assign rem_sub    = rem_sh - {1'b0, div_den_ff};
   assign div_q      = div_num_ff[31:0];
   assign div_val    = sgn_ff ? $signed(-div_q) : $signed(div_q);
   assign q10        = {1'b0, mul_p_ff[RECIP10_SHIFT+30:RECIP10_SHIFT]};
   assign div10_val  = sgn_ff ? $signed(-q10) : $signed(q10);
   assign raw_xw     = $signed({2'b00, req_data.pixel_x, 1'b1}) - $signed({2'b00, image_width_ff});
   assign raw_yw     = $signed({2'b00, image_height_ff}) - $signed({2'b00, req_data.pixel_y, 1'b1});
   assign out_sh     = mul_p_ff >>> FRAC_BITS;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      focal_length_in = focal_length_ff;
      max_steps_in    = max_steps_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata[12:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata[12:0];
            CSR_FOCAL_LENGTH: focal_length_in = csr_wdata;
            default:          max_steps_in    = csr_wdata[7:0];
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_LSQ;
         S_LSQ:       if (k_ff == 2'd3) state_in = S_SQRT;
         S_SQRT:      if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = S_LEN_DONE;
         S_LEN_DONE: begin
            if (smode_ff) begin
               priority case (phase_ff)
                  PH_MARCH: state_in = S_MUPD;
                  PH_NZ:    state_in = S_LSQ;
                  default:  state_in = S_SCENE;
               endcase
            end else if (len_u == 32'd0) begin
               state_in = S_NORM_DONE;
            end else begin
               state_in = S_DLOAD;
            end
         end
         // the shadow scale is a reciprocal multiply, the rest use the divider
         S_DLOAD:     state_in = (phase_ff == PH_SHADE) ? S_DEND : S_DIV;
         S_DIV:       if (cnt_ff == CNT_W'(DIV_W - 1)) state_in = S_DEND;
         S_DEND: begin
            if (phase_ff == PH_SHADE) state_in = S_SCALE;
            else if (k_ff == 2'd2) state_in = S_NORM_DONE;
            else state_in = S_DLOAD;
         end
         S_NORM_DONE: begin
            priority case (phase_ff)
               PH_DIR:  state_in = S_MCHK;
               PH_LDIR: state_in = S_SCENE;
               default: state_in = S_DOT;
            endcase
         end
         S_MCHK: begin
            if (!march_done) state_in = S_MMUL;
            else if (!msel_ff) state_in = S_MMUL;
            else if (shadow_now) state_in = S_DLOAD;
            else state_in = S_SCALE;
         end
         S_MMUL: begin
            if (k_ff == 2'd3) state_in = (phase_ff == PH_HIT) ? S_LSQ : S_SCENE;
         end
         S_SCENE:     state_in = S_LSQ;
         S_MUPD:      state_in = S_MCHK;
         S_DOT:       if (k_ff == 2'd3) state_in = S_MCHK;
         S_SCALE:     state_in = S_SCALE2;
         S_SCALE2:    state_in = S_OUT;
         S_OUT:       if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and sequencer outputs
   always_comb begin
      phase_in   = phase_ff;
      vin_in     = vin_ff;
      p_in       = p_ff;
      org_in     = org_ff;
      mdir_in    = mdir_ff;
      hit_in     = hit_ff;
      ldir_in    = ldir_ff;
      vout_in    = vout_ff;
      t_in       = t_ff;
      s_in       = s_ff;
      d0_in      = d0_ff;
      ldist_in   = ldist_ff;
      diff_in    = diff_ff;
      dot_in     = dot_ff;
      n_in       = n_ff;
      brk_in     = brk_ff;
      msel_in    = msel_ff;
      smode_in   = smode_ff;
      shadow_in  = shadow_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      one_in     = one_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      sgn_in     = sgn_ff;
      ires_in    = ires_ff;
      mul_a      = '0;
      mul_b      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               vin_in[0] = $signed({{10{raw_xw[14]}}, raw_xw, 7'b0});
               vin_in[1] = $signed({{10{raw_yw[14]}}, raw_yw, 7'b0});
               vin_in[2] = -$signed({12'b0, focal_length_ff});
               phase_in  = PH_DIR;
               smode_in  = 1'b0;
               k_in      = 2'd0;
            end
         end
         S_LSQ: begin
            // squares go through the multiplier and are summed in the next cycle
            mul_a  = $signed({1'b0, mag32(pick3(vin_ff, k_ff))});
            mul_b  = mul_a;
            acc_in = (k_ff == 2'd0) ? 64'd0 : acc_ff + mul_p_ff[63:0];
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               res_in = 64'd0;
               one_in = 64'd1 << 62;
               cnt_in = '0;
               k_in   = 2'd0;
            end
         end
         S_SQRT: begin
            if (sq_ge) begin
               acc_in = acc_ff - sq_sum;
               res_in = (res_ff >> 1) + one_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         S_LEN_DONE: begin
            if (smode_ff) begin
               priority case (phase_ff)
                  PH_MARCH: s_in = scene_s;
                  PH_D0: begin
                     d0_in    = scene_s;
                     p_in     = hit_ff;
                     p_in[0]  = sat34(sx34(hit_ff[0]) + sx34(FX_EPS));
                     phase_in = PH_NX;
                  end
                  PH_NX: begin
                     vout_in[0] = nrm_new;
                     p_in       = hit_ff;
                     p_in[1]    = sat34(sx34(hit_ff[1]) + sx34(FX_EPS));
                     phase_in   = PH_NY;
                  end
                  PH_NY: begin
                     vout_in[1] = nrm_new;
                     p_in       = hit_ff;
                     p_in[2]    = sat34(sx34(hit_ff[2]) + sx34(FX_EPS));
                     phase_in   = PH_NZ;
                  end
                  default: begin
                     vin_in[0] = vout_ff[0];
                     vin_in[1] = vout_ff[1];
                     vin_in[2] = nrm_new;
                     phase_in  = PH_NRM;
                     smode_in  = 1'b0;
                     k_in      = 2'd0;
                  end
               endcase
            end else begin
               if (phase_ff == PH_LDIR) ldist_in = len_sat;
               k_in = 2'd0;
               if (len_u == 32'd0) begin
                  vout_in[0] = '0;
                  vout_in[1] = '0;
                  vout_in[2] = '0;
               end
            end
         end
         S_DLOAD: begin
            if (phase_ff == PH_SHADE) begin
               mul_a  = $signed({1'b0, mag32(diff_ff)});
               mul_b  = RECIP10;
               sgn_in = diff_ff[31];
            end else begin
               div_num_in = {mag32(pick3(vin_ff, k_ff)), {FRAC_BITS{1'b0}}};
               div_den_in = len_u;
               sgn_in     = pick3(vin_ff, k_ff) < 0;
            end
            div_rem_in = '0;
            cnt_in     = '0;
         end
         S_DIV: begin
            div_rem_in = div_ge ? rem_sub[31:0] : rem_sh[31:0];
            div_num_in = {div_num_ff[DIV_W-2:0], div_ge};
            cnt_in     = cnt_ff + CNT_W'(1);
         end
         S_DEND: begin
            if (phase_ff == PH_SHADE) begin
               diff_in = div10_val;
            end else begin
               vout_in[k_ff] = div_val;
               k_in = k_ff + 2'd1;
            end
         end
         S_NORM_DONE: begin
            priority case (phase_ff)
               PH_DIR: begin
                  mdir_in  = vout_ff;
                  org_in[0] = '0;
                  org_in[1] = FX_ONE;
                  org_in[2] = '0;
                  t_in     = '0;
                  n_in     = '0;
                  brk_in   = 1'b0;
                  msel_in  = 1'b0;
                  phase_in = PH_MARCH;
               end
               PH_LDIR: begin
                  ldir_in  = vout_ff;
                  p_in     = hit_ff;
                  phase_in = PH_D0;
               end
               default: begin
                  phase_in = PH_DIFF;
                  k_in     = 2'd0;
               end
            endcase
         end
         S_MCHK: begin
            k_in = 2'd0;
            if (march_done) begin
               if (!msel_ff) begin
                  phase_in = PH_HIT;
               end else begin
                  shadow_in = shadow_now;
                  if (shadow_now) phase_in = PH_SHADE;
               end
            end
         end
         S_MMUL: begin
            mul_a = 33'(pick3(mdir_ff, k_ff));
            mul_b = $signed({t_ff[31], t_ff});
            if (k_ff != 2'd0) p_in[km1] = p_new;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               k_in = 2'd0;
               if (phase_ff == PH_HIT) begin
                  hit_in[0] = p_ff[0];
                  hit_in[1] = p_ff[1];
                  hit_in[2] = p_new;
                  vin_in[0] = sat34(-sx34(p_ff[0]));
                  vin_in[1] = sat34(sx34(FX_FIVE) - sx34(p_ff[1]));
                  vin_in[2] = sat34(sx34(FX_MSIX) - sx34(p_new));
                  phase_in  = PH_LDIR;
                  smode_in  = 1'b0;
               end
            end
         end
         S_SCENE: begin
            // scene distance: offset the point to the sphere centre first
            vin_in[0] = p_ff[0];
            vin_in[1] = sat34(sx34(p_ff[1]) - sx34(FX_ONE));
            vin_in[2] = sat34(sx34(p_ff[2]) + sx34(FX_SIX));
            smode_in  = 1'b1;
            k_in      = 2'd0;
         end
         S_MUPD: begin
            t_in   = t_next;
            n_in   = n_ff + 8'd1;
            brk_in = (s_ff < FX_SURF) || (t_next > FX_FAR);
         end
         S_DOT: begin
            mul_a = 33'(pick3(ldir_ff, k_ff));
            mul_b = 33'(pick3(vout_ff, k_ff));
            dot_in = (k_ff == 2'd1) ? sx34(f_res) : dot_ff + sx34(f_res);
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               diff_in   = sat34(dot_ff + sx34(f_res));
               org_in[0] = sat34(sx34(hit_ff[0]) + sx34(ldir_ff[0]));
               org_in[1] = sat34(sx34(hit_ff[1]) + sx34(ldir_ff[1]));
               org_in[2] = sat34(sx34(hit_ff[2]) + sx34(ldir_ff[2]));
               mdir_in   = ldir_ff;
               t_in      = '0;
               n_in      = '0;
               brk_in    = 1'b0;
               msel_in   = 1'b1;
               phase_in  = PH_MARCH;
               k_in      = 2'd0;
            end
         end
         S_SCALE: begin
            mul_a = $signed({diff_ff[31], diff_ff});
            mul_b = 33'sd255;
         end
         S_SCALE2: begin
            if (diff_ff[31]) ires_in = 8'd0;
            else if (out_sh > 66'sd255) ires_in = 8'd255;
            else ires_in = out_sh[7:0];
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.intensity = ires_ff;
               rsp_data_in.shadowed  = shadow_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         image_width_ff  <= 13'd640;
         image_height_ff <= 13'd480;
         focal_length_ff <= 20'd106417;
         max_steps_ff    <= 8'd128;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         focal_length_ff <= focal_length_in;
         max_steps_ff    <= max_steps_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      vin_ff     <= vin_in;
      p_ff       <= p_in;
      org_ff     <= org_in;
      mdir_ff    <= mdir_in;
      hit_ff     <= hit_in;
      ldir_ff    <= ldir_in;
      vout_ff    <= vout_in;
      t_ff       <= t_in;
      s_ff       <= s_in;
      d0_ff      <= d0_in;
      ldist_ff   <= ldist_in;
      diff_ff    <= diff_in;
      dot_ff     <= dot_in;
      n_ff       <= n_in;
      brk_ff     <= brk_in;
      msel_ff    <= msel_in;
      smode_ff   <= smode_in;
      shadow_ff  <= shadow_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
      one_ff     <= one_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      sgn_ff     <= sgn_in;
      ires_ff    <= ires_in;
      mul_p_ff   <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
   end

   `RMSP_ASSERT_SAME(a_div_den_nonzero, state_ff == S_DIV, div_den_ff != 32'd0)
   `RMSP_ASSERT_SAME(a_sqrt_bound, state_ff == S_SQRT, cnt_ff < CNT_W'(SQRT_STEPS))
   `RMSP_ASSERT_SAME(a_step_limit, state_ff == S_MMUL && phase_ff == PH_MARCH,
                     n_ff < max_steps_ff)
   `RMSP_ASSERT_NEXT(a_out_wait, state_ff == S_OUT && rsp_valid_ff && rsp_stall,
                     state_ff == S_OUT && rsp_valid_ff)

endmodule

// File: verif/ray_march_shade_pixel_checker.sv
// checker for the ray march shading unit: watches both channels and the csr port,
// predicts each pixel's grey level and compares it with what comes out
// depends on rmsp_pkg
module ray_march_shade_pixel_checker import rmsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  rmsp_req_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rmsp_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    shades_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      longint x, y, z;
   } point_type;

   localparam longint ONE  = longint'(1) << FRAC_BITS;
   localparam longint SURF = ((longint'(25) << FRAC_BITS) + 500) / 1000;
   localparam longint EPS  = ((longint'(1) << FRAC_BITS) + 50) / 100;

   logic [12:0] width_reg, height_reg;
   logic [19:0] focal_reg;
   logic [7:0]  steps_reg;
   rmsp_rsp_type shade_queue[$];

   function automatic longint clip32(longint v);
      if (v > longint'(32'sh7fffffff)) return longint'(32'sh7fffffff);
      if (v < -longint'(64'sd2147483648)) return -longint'(64'sd2147483648);
      return v;
   endfunction

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint fxmul(longint a, longint b);
      return clip32((a * b) / ONE);
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, bitv, rem;
      res = 0;
      bitv = 64'd1 << 62;
      rem = n;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint length3(point_type v);
      longint unsigned ax, ay, az;
      ax = abs64(v.x);
      ay = abs64(v.y);
      az = abs64(v.z);
      return longint'(root64(ax * ax + ay * ay + az * az));
   endfunction

   function automatic longint unit_comp(longint c, longint len);
      longint q;
      q = longint'((abs64(c) << FRAC_BITS) / longint'(unsigned'(len)));
      return c < 0 ? -q : q;
   endfunction

   function automatic point_type to_unit(point_type v);
      point_type r;
      longint len;
      len = length3(v);
      r = '{0, 0, 0};
      if (len != 0) begin
         r.x = unit_comp(v.x, len);
         r.y = unit_comp(v.y, len);
         r.z = unit_comp(v.z, len);
      end
      return r;
   endfunction

   // distance to the nearer of the sphere at (0,1,-6) and the ground plane
   function automatic longint scene_dist(point_type p);
      point_type q;
      longint sd;
      q.x = p.x;
      q.y = clip32(p.y - ONE);
      q.z = clip32(p.z + 6 * ONE);
      sd = clip32(clip32(length3(q)) - ONE);
      return sd < p.y ? sd : p.y;
   endfunction

   function automatic point_type along_ray(point_type o, point_type d, longint t);
      point_type p;
      p.x = clip32(o.x + fxmul(d.x, t));
      p.y = clip32(o.y + fxmul(d.y, t));
      p.z = clip32(o.z + fxmul(d.z, t));
      return p;
   endfunction

   function automatic longint trace_dist(point_type o, point_type d, int steps);
      longint t, s;
      t = 0;
      for (int n = 0; n < steps; n++) begin
         s = scene_dist(along_ray(o, d, t));
         t = clip32(t + s);
         if (s < SURF || t > clip32(128 * ONE)) break;
      end
      return t;
   endfunction

   function automatic rmsp_rsp_type shade_pixel(rmsp_req_type pix);
      point_type cam, raw, dir, hit, lvec, ldir, nrm, probe, start;
      longint t, d0, diff, sdist, ldist, v;
      rmsp_rsp_type r;
      cam = '{0, ONE, 0};
      raw.x = (2 * longint'(pix.pixel_x) + 1 - longint'(width_reg)) * 128;
      raw.y = (longint'(height_reg) - 2 * longint'(pix.pixel_y) - 1) * 128;
      raw.z = -longint'(focal_reg);
      dir = to_unit(raw);
      t = trace_dist(cam, dir, steps_reg);
      hit = along_ray(cam, dir, t);
      lvec.x = clip32(0 - hit.x);
      lvec.y = clip32(5 * ONE - hit.y);
      lvec.z = clip32(-6 * ONE - hit.z);
      ldir = to_unit(lvec);
      d0 = scene_dist(hit);
      probe = hit;
      probe.x = clip32(hit.x + EPS);
      nrm.x = clip32(scene_dist(probe) - d0);
      probe = hit;
      probe.y = clip32(hit.y + EPS);
      nrm.y = clip32(scene_dist(probe) - d0);
      probe = hit;
      probe.z = clip32(hit.z + EPS);
      nrm.z = clip32(scene_dist(probe) - d0);
      nrm = to_unit(nrm);
      diff = clip32(fxmul(ldir.x, nrm.x) + fxmul(ldir.y, nrm.y) + fxmul(ldir.z, nrm.z));
      start.x = clip32(hit.x + ldir.x);
      start.y = clip32(hit.y + ldir.y);
      start.z = clip32(hit.z + ldir.z);
      sdist = trace_dist(start, ldir, steps_reg);
      ldist = clip32(length3(lvec));
      r.shadowed = sdist < ldist;
      if (r.shadowed) diff = diff / 10;
      v = (diff * 255) / ONE;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r.intensity = v[7:0];
      return r;
   endfunction

   assign shades_pending = shade_queue.size();

   always @(posedge clock) begin
      rmsp_rsp_type want;
      if (reset) begin
         width_reg <= 13'd640;
         height_reg <= 13'd480;
         focal_reg <= 20'd106417;
         steps_reg <= 8'd128;
         shade_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg <= csr_wdata[12:0];
               CSR_IMAGE_HEIGHT: height_reg <= csr_wdata[12:0];
               CSR_FOCAL_LENGTH: focal_reg <= csr_wdata;
               CSR_MAX_STEPS:    steps_reg <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            shade_queue.push_back(shade_pixel(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (shade_queue.size() == 0) begin
               $display("%0t: unexpected transaction, got intensity %0d shadowed %0d",
                        $time, rsp_data.intensity, rsp_data.shadowed);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = shade_queue.pop_front();
               if (want.intensity !== rsp_data.intensity ||
                   want.shadowed !== rsp_data.shadowed) begin
                  $display("%0t: expected intensity %0d shadowed %0d, got %0d %0d",
                           $time, want.intensity, want.shadowed,
                           rsp_data.intensity, rsp_data.shadowed);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: verif/ray_march_shade_pixel_unit_tb.sv
// testbench top for the ray march shading unit: clock, reset, pixel stimulus,
// csr phases, receiver stalls and the verdict
// depends on rmsp_pkg, ray_march_shade_pixel_unit and ray_march_shade_pixel_checker
module ray_march_shade_pixel_unit_tb import rmsp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   rmsp_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rmsp_rsp_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatch_count;
   int                    shades_pending;

   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int img_w, img_h;

   ray_march_shade_pixel_unit uut (.*);
   ray_march_shade_pixel_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic write_regs(int w, int h, int focal, int steps);
      csr_we <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_FOCAL_LENGTH;
      csr_wdata <= CSR_DATA_W'(focal);
      @(posedge clock);
      csr_index <= CSR_MAX_STEPS;
      csr_wdata <= CSR_DATA_W'(steps);
      @(posedge clock);
      csr_we <= 1'b0;
      img_w = w;
      img_h = h;
   endtask

   task automatic send_pixel(int x, int y);
      req_valid <= 1'b1;
      req_data.pixel_x <= 12'(x);
      req_data.pixel_y <= 12'(y);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (shades_pending != 0) @(posedge clock);
   endtask

   task automatic send_random(int count);
      int x, y;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 8) begin
            x = $urandom_range(0, (img_w > 4096 ? 4096 : img_w) - 1);
            y = $urandom_range(0, (img_h > 4096 ? 4096 : img_h) - 1);
         end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
         end
         send_pixel(x, y);
      end
   endtask

   // receiver: random stall bursts, one long hold-off on request, none at the end
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (20000) @(posedge clock);
            hold_request = 1'b0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin
      int w, h;
      img_w = 640;
      img_h = 480;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: corners, centre, sphere, floor and sky
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      send_pixel(319, 239);
      send_pixel(320, 240);
      send_pixel(639, 479);
      send_pixel(320, 470);
      send_pixel(320, 100);
      send_pixel(2730, 1365);
      drain();

      // zero step count and zero-length ray
      write_regs(1, 1, 0, 0);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(0, 1);
      drain();
      write_regs(1, 1, 0, 5);
      send_pixel(0, 0);
      send_pixel(2048, 2048);
      drain();

      // widest registers and the step limit at its top
      write_regs(8191, 8191, 1048575, 255);
      send_pixel(4095, 4095);
      send_pixel(0, 0);
      send_pixel(4095, 0);
      send_pixel(1365, 2730);
      drain();

      for (int p = 0; p < 6; p++) begin
         w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4096) : $urandom_range(1, 200);
         h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4096) : $urandom_range(1, 200);
         write_regs(w, h,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                              : $urandom_range(h * 128, h * 512),
                    p == 1 ? $urandom_range(1, 20) : $urandom_range(1, 40));
         if (p == 1) hold_request = 1'b1;
         if (p == 5) quiet = 1'b1;
         send_random(32);
         // pause until every pixel so far has come back
         if (p == 2) drain();
         send_random(33);
         drain();
      end

      repeat (1000) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #500ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
